>>> hw/rtl/mpd_pkg.sv
// Shared constants, codes and controller/datapath handshake types of the part deframer.
`default_nettype none

package mpd_pkg;

  localparam int MAX_PENDING_SPACES = 16;
  localparam int MAX_BOUNDARY_BYTES = 56;
  localparam int DELIM_HEAD_BYTES   = 4;
  localparam int DELIM_MAX_BYTES    = DELIM_HEAD_BYTES + MAX_BOUNDARY_BYTES;
  localparam int DELIM_TBL_BYTES    = 64;
  localparam int BLANK_CNT_W        = $clog2(MAX_PENDING_SPACES + 1);
  localparam int BLANK_IDX_W        = $clog2(MAX_PENDING_SPACES);
  localparam int MATCH_W            = 6;
  localparam int BLEN_W             = 6;
  localparam int NUM_WORDS          = 7;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_W              = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_LENGTH = 3'd0;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_LINE_END  = 3'd2,
    KIND_HDR_DONE  = 3'd3,
    KIND_BODY      = 3'd4,
    KIND_PART_END  = 3'd5,
    KIND_ERROR     = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NO_COLON   = 2'd0,
    ERR_BAD_TAIL   = 2'd1,
    ERR_BLANK_OVF  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    BSEL_ZERO,
    BSEL_IN,
    BSEL_CR,
    BSEL_BLANK,
    BSEL_REPLAY
  } bsel_t;

  typedef struct packed {
    logic  accept;
    logic  clr_hdr;
    logic  blank_push;
    logic  blank_pop;
    logic  blank_clr;
    logic  match_inc;
    logic  match_clr;
    logic  match_replay;
    logic  rep_start;
    logic  rep_step;
    logic  emit;
    kind_t kind;
    bsel_t bsel;
    logic  fin;
    err_t  err;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd;
    logic is_blank;
    logic is_colon;
    logic is_cr;
    logic is_lf;
    logic is_dash;
    logic blank_none;
    logic blank_full;
    logic d_hit;
    logic d_full;
    logic rep_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/mpd_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;
  modport source (output valid, command, in_byte, input ready);
  modport sink (input valid, command, in_byte, output ready);
endinterface

interface mpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       final_part;
  logic [1:0] error_code;
  logic       last_of_run;
  modport source (output valid, kind, out_byte, final_part, error_code, last_of_run,
                  input ready);
  modport sink (input valid, kind, out_byte, final_part, error_code, last_of_run,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mpd_datapath.sv
// Datapath: boundary registers, delimiter matcher, blank store, replay shifter, result register.
`default_nettype none

module mpd_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpd_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         in_command,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [2:0]                        out_kind,
  output logic [7:0]                        out_byte,
  output logic                              out_final_part,
  output logic [1:0]                        out_error_code,
  output logic                              out_last_of_run,
  input  wire mpd_pkg::dp_cmd_t             cmd,
  output mpd_pkg::dp_sts_t                  sts
);
  import mpd_pkg::*;

  logic [BLEN_W-1:0]      len_r;
  logic [CFG_W-1:0]       words_r [NUM_WORDS];
  logic                   cmd_r;
  logic [7:0]             byte_r;
  logic [MATCH_W-1:0]     match_r;
  logic [BLANK_CNT_W-1:0] bcnt_r;
  logic [MAX_PENDING_SPACES-1:0] bkind_r;
  logic [MATCH_W-1:0]     rep_m_r;
  logic [MATCH_W-1:0]     rep_s_r;
  logic [7:0]             sh_r [DELIM_TBL_BYTES];
  logic                   ov_r;
  logic [2:0]             ok_r;
  logic [7:0]             ob_r;
  logic                   of_r;
  logic [1:0]             oe_r;
  logic                   ol_r;

  logic [7:0]             dbyte [DELIM_TBL_BYTES];
  logic [MATCH_W-1:0]     blen;
  logic [MATCH_W-1:0]     dlen;
  logic [MATCH_W-1:0]     m_eff;
  logic [MATCH_W-1:0]     diff;
  logic                   shift_ok;
  logic [7:0]             rep_byte;
  logic [7:0]             sel_byte;

  // Delimiter table: CR LF - - followed by the boundary bytes, zero beyond.
  always_comb begin
    for (int i = 0; i < DELIM_TBL_BYTES; i++) begin
      dbyte[i] = 8'd0;
    end
    dbyte[0] = CH_CR;
    dbyte[1] = CH_LF;
    dbyte[2] = CH_DASH;
    dbyte[3] = CH_DASH;
    for (int i = 0; i < MAX_BOUNDARY_BYTES; i++) begin
      dbyte[DELIM_HEAD_BYTES + i] = words_r[i / 8][(i % 8) * 8 +: 8];
    end
  end

  always_comb begin
    if (len_r == '0) begin
      blen = MATCH_W'(1);
    end else if (len_r > BLEN_W'(MAX_BOUNDARY_BYTES)) begin
      blen = MATCH_W'(MAX_BOUNDARY_BYTES);
    end else begin
      blen = len_r;
    end
    dlen  = blen + MATCH_W'(DELIM_HEAD_BYTES);
    m_eff = (match_r >= dlen) ? dlen - MATCH_W'(1) : match_r;
  end

  // Replay check: does the held sequence shifted by rep_s still prefix the delimiter?
  always_comb begin
    diff     = rep_m_r - rep_s_r;
    shift_ok = (dbyte[diff] == byte_r);
    for (int k = 0; k < DELIM_TBL_BYTES - 1; k++) begin
      if (MATCH_W'(k) < diff && sh_r[k + 1] != dbyte[k]) begin
        shift_ok = 1'b0;
      end
    end
    rep_byte = (rep_s_r <= rep_m_r) ? sh_r[0] : byte_r;
  end

  always_comb begin
    unique case (cmd.bsel)
      BSEL_IN:     sel_byte = byte_r;
      BSEL_CR:     sel_byte = CH_CR;
      BSEL_BLANK:  sel_byte = bkind_r[0] ? CH_TAB : CH_SPACE;
      BSEL_REPLAY: sel_byte = rep_byte;
      default:     sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    sts.cmd        = cmd_r;
    sts.is_blank   = (byte_r == CH_SPACE) || (byte_r == CH_TAB);
    sts.is_colon   = (byte_r == CH_COLON);
    sts.is_cr      = (byte_r == CH_CR);
    sts.is_lf      = (byte_r == CH_LF);
    sts.is_dash    = (byte_r == CH_DASH);
    sts.blank_none = (bcnt_r == '0);
    sts.blank_full = (bcnt_r >= BLANK_CNT_W'(MAX_PENDING_SPACES));
    sts.d_hit      = (dbyte[m_eff] == byte_r);
    sts.d_full     = (m_eff + MATCH_W'(1) == dlen);
    sts.rep_last   = (rep_s_r == rep_m_r + MATCH_W'(1)) || shift_ok;
    sts.out_free   = !ov_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= BLEN_W'(1);
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_BOUNDARY_LENGTH) begin
        len_r <= cfg_wdata[BLEN_W-1:0];
      end
      for (int i = 0; i < NUM_WORDS; i++) begin
        if (cfg_index == CFG_IDX_W'(i + 1)) begin
          words_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_command;
      byte_r <= in_byte;
    end
    if (cmd.rep_start) begin
      rep_m_r <= m_eff;
      rep_s_r <= MATCH_W'(1);
      for (int i = 0; i < DELIM_TBL_BYTES; i++) begin
        sh_r[i] <= dbyte[i];
      end
    end else if (cmd.rep_step) begin
      rep_s_r <= rep_s_r + MATCH_W'(1);
      for (int i = 0; i < DELIM_TBL_BYTES - 1; i++) begin
        sh_r[i] <= sh_r[i + 1];
      end
      sh_r[DELIM_TBL_BYTES-1] <= 8'd0;
    end
    if (cmd.emit) begin
      ok_r <= cmd.kind;
      ob_r <= sel_byte;
      of_r <= cmd.fin;
      oe_r <= cmd.err;
      ol_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
      bcnt_r  <= '0;
      bkind_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cmd.clr_hdr || cmd.match_clr) begin
        match_r <= '0;
      end else if (cmd.match_inc) begin
        match_r <= m_eff + MATCH_W'(1);
      end else if (cmd.match_replay) begin
        match_r <= rep_m_r - rep_s_r + MATCH_W'(1);
      end
      if (cmd.clr_hdr || cmd.blank_clr) begin
        bcnt_r  <= '0;
        bkind_r <= '0;
      end else if (cmd.blank_push) begin
        bkind_r[bcnt_r[BLANK_IDX_W-1:0]] <= (byte_r == CH_TAB);
        bcnt_r <= bcnt_r + BLANK_CNT_W'(1);
      end else if (cmd.blank_pop) begin
        bkind_r <= bkind_r >> 1;
        bcnt_r  <= bcnt_r - BLANK_CNT_W'(1);
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = ok_r;
  assign out_byte        = ob_r;
  assign out_final_part  = of_r;
  assign out_error_code  = oe_r;
  assign out_last_of_run = ol_r;

endmodule

`default_nettype wire

>>> hw/rtl/mpd_ctrl.sv
// Controller: parse phase, held carriage return and the per-item step sequencer.
`default_nettype none

module mpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mpd_pkg::dp_sts_t  sts,
  output mpd_pkg::dp_cmd_t       cmd
);
  import mpd_pkg::*;

  typedef enum logic [3:0] {
    PH_LINE_START, PH_NAME, PH_VALUE_LEAD, PH_VALUE, PH_BODY,
    PH_AFTER_BOUND, PH_AFTER_DASH, PH_AFTER_CR, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_HDR, S_FLUSH, S_REPLAY
  } state_t;

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic   cr_r, cr_nxt;
  logic   opcr_r, opcr_nxt;

  logic   blank, colon, step2_emits, hlast;
  state_t after;
  bsel_t  obsel;

  always_comb begin
    blank       = !opcr_r && sts.is_blank;
    colon       = !opcr_r && sts.is_colon;
    // After a lone CR the phase is name or value; predict whether the byte behind it emits.
    step2_emits = !sts.is_cr &&
                  (((ph_r == PH_LINE_START) || (ph_r == PH_NAME)) ? !sts.is_colon
                                                                  : !sts.is_blank);
    hlast       = opcr_r ? !step2_emits : 1'b1;
    after       = opcr_r ? S_DISP : S_IDLE;
    obsel       = opcr_r ? BSEL_CR : BSEL_IN;
  end

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    cr_nxt   = cr_r;
    opcr_nxt = opcr_r;
    cmd      = '0;
    cmd.last = 1'b1;
    in_ready = (st_r == S_IDLE);
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.out_free) begin
          st_nxt = S_IDLE;
          if (sts.cmd) begin
            ph_nxt      = PH_LINE_START;
            cr_nxt      = 1'b0;
            cmd.clr_hdr = 1'b1;
          end else begin
            unique case (ph_r)
              PH_LINE_START, PH_NAME, PH_VALUE_LEAD, PH_VALUE: begin
                if (cr_r) begin
                  cr_nxt = 1'b0;
                  if (sts.is_lf) begin
                    cmd.emit = 1'b1;
                    if (ph_r == PH_LINE_START) begin
                      cmd.kind      = KIND_HDR_DONE;
                      cmd.match_clr = 1'b1;
                      ph_nxt        = PH_BODY;
                    end else if (ph_r == PH_NAME) begin
                      cmd.kind    = KIND_ERROR;
                      cmd.err     = ERR_NO_COLON;
                      cmd.clr_hdr = 1'b1;
                      ph_nxt      = PH_ERROR;
                    end else begin
                      cmd.kind      = KIND_LINE_END;
                      cmd.blank_clr = 1'b1;
                      ph_nxt        = PH_LINE_START;
                    end
                  end else begin
                    opcr_nxt = 1'b1;
                    st_nxt   = S_HDR;
                  end
                end else if (sts.is_cr) begin
                  cr_nxt = 1'b1;
                end else begin
                  opcr_nxt = 1'b0;
                  st_nxt   = S_HDR;
                end
              end
              PH_BODY: begin
                if (sts.d_hit) begin
                  if (sts.d_full) begin
                    cmd.match_clr = 1'b1;
                    ph_nxt        = PH_AFTER_BOUND;
                  end else begin
                    cmd.match_inc = 1'b1;
                  end
                end else begin
                  cmd.rep_start = 1'b1;
                  st_nxt        = S_REPLAY;
                end
              end
              PH_AFTER_BOUND: begin
                if (sts.is_dash) begin
                  ph_nxt = PH_AFTER_DASH;
                end else if (sts.is_cr) begin
                  ph_nxt = PH_AFTER_CR;
                end else begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_ERROR;
                  cmd.err     = ERR_BAD_TAIL;
                  cmd.clr_hdr = 1'b1;
                  ph_nxt      = PH_ERROR;
                end
              end
              PH_AFTER_DASH, PH_AFTER_CR: begin
                cmd.emit = 1'b1;
                if (ph_r == PH_AFTER_DASH && sts.is_dash) begin
                  cmd.kind = KIND_PART_END;
                  cmd.fin  = 1'b1;
                  ph_nxt   = PH_DONE;
                end else if (ph_r == PH_AFTER_CR && sts.is_lf) begin
                  cmd.kind    = KIND_PART_END;
                  cmd.clr_hdr = 1'b1;
                  cr_nxt      = 1'b0;
                  ph_nxt      = PH_LINE_START;
                end else begin
                  cmd.kind    = KIND_ERROR;
                  cmd.err     = ERR_BAD_TAIL;
                  cmd.clr_hdr = 1'b1;
                  ph_nxt      = PH_ERROR;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_HDR: begin
        if (sts.out_free) begin
          cmd.bsel = obsel;
          cmd.last = hlast;
          unique case (ph_r)
            PH_LINE_START, PH_NAME: begin
              ph_nxt = PH_NAME;
              if (colon) begin
                ph_nxt = PH_VALUE_LEAD;
              end else begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_NAME;
              end
              opcr_nxt = 1'b0;
              st_nxt   = after;
            end
            PH_VALUE_LEAD: begin
              if (!blank) begin
                ph_nxt   = PH_VALUE;
                cmd.emit = 1'b1;
                cmd.kind = KIND_VALUE;
              end
              opcr_nxt = 1'b0;
              st_nxt   = after;
            end
            default: begin
              if (blank) begin
                if (sts.blank_full) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_ERROR;
                  cmd.err     = ERR_BLANK_OVF;
                  cmd.bsel    = BSEL_ZERO;
                  cmd.last    = 1'b1;
                  cmd.clr_hdr = 1'b1;
                  cr_nxt      = 1'b0;
                  ph_nxt      = PH_ERROR;
                  st_nxt      = S_IDLE;
                end else begin
                  cmd.blank_push = 1'b1;
                  st_nxt         = after;
                end
                opcr_nxt = 1'b0;
              end else if (!sts.blank_none) begin
                st_nxt = S_FLUSH;
              end else begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_VALUE;
                opcr_nxt = 1'b0;
                st_nxt   = after;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_VALUE;
          if (!sts.blank_none) begin
            cmd.blank_pop = 1'b1;
            cmd.bsel      = BSEL_BLANK;
            cmd.last      = 1'b0;
          end else begin
            cmd.bsel = obsel;
            cmd.last = hlast;
            opcr_nxt = 1'b0;
            st_nxt   = after;
          end
        end
      end
      S_REPLAY: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_BODY;
          cmd.bsel = BSEL_REPLAY;
          cmd.last = sts.rep_last;
          if (sts.rep_last) begin
            cmd.match_replay = 1'b1;
            st_nxt           = S_IDLE;
          end else begin
            cmd.rep_step = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ph_r   <= PH_LINE_START;
      cr_r   <= 1'b0;
      opcr_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      cr_r   <= cr_nxt;
      opcr_r <= opcr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/multipart_part_deframer.sv
// Top level of the multipart part deframer: controller plus datapath.
//
// The block splits one part of a multipart body out of a byte stream that
// starts at the part's headers. Items enter on in_ch (command, in_byte) and
// results leave on out_ch (kind, out_byte, final_part, error_code,
// last_of_run); both are valid/ready channels. The boundary string is set
// through the cfg_ write port; the user must do so only while the block is
// idle, as the block itself does not enforce it. An item is taken in the
// idle state and decoded in the dispatch state; an item that gives no
// result, such as a matched delimiter byte, returns to idle from there. A
// held run of blanks is flushed one blank per cycle, and a broken delimiter
// prefix is replayed through a byte shifter one body byte per cycle, both
// while the receiver keeps ready high. A lone carriage return is held and
// emitted before the byte behind it is decoded. The output register frees
// as soon as the receiver takes a result. While the receiver stalls the
// sequencer waits, but an item can still be taken in the idle state; no
// further item is accepted until that item is done. Synchronous reset
// returns the parser to the start of a header line, sets the boundary
// length to one and clears the boundary words.
`default_nettype none

module multipart_part_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpd_pkg::CFG_W-1:0]     cfg_wdata,
  mpd_in_if.sink                             in_ch,
  mpd_out_if.source                          out_ch
);
  import mpd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decides each step; the datapath does the compares and holds the payload.
  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_ch.command),
    .in_byte         (in_ch.in_byte),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_byte        (out_ch.out_byte),
    .out_final_part  (out_ch.final_part),
    .out_error_code  (out_ch.error_code),
    .out_last_of_run (out_ch.last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
